// ===== rtl/gmuf_pkg.sv =====
// ----------------------------------------------------------------------------
// gmuf_pkg: shared types and constants of the GRE multicast UDP filter
// Holds the request and result structures, the protocol constants and the
// configuration register indexes used across the filter.
// ----------------------------------------------------------------------------
package gmuf_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIndexWidth = 1;
    localparam logic [CfgIndexWidth-1:0] CFG_TARGET_GROUP = 1'b0;
    localparam logic [CfgIndexWidth-1:0] CFG_TARGET_PORT  = 1'b1;

    // Protocol constants
    localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_GRE      = 8'd47;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam int unsigned GRE_BIT_CSUM   = 15;
    localparam int unsigned GRE_BIT_KEY    = 13;
    localparam int unsigned GRE_BIT_SEQ    = 12;
    localparam logic [3:0]  MCAST_PREFIX   = 4'hE;
    localparam logic [5:0]  IHL_MIN        = 6'd20;

    // Byte positions within the frame
    localparam logic [7:0] POS_ETH_TYPE_END = 8'd13;
    localparam logic [7:0] POS_OUTER_IP     = 8'd14;
    localparam logic [7:0] POS_OUTER_PROTO  = 8'd23;
    localparam logic [7:0] POS_OUTER_END    = 8'd34;
    localparam logic [7:0] POS_MAX          = 8'd255;

    // Offsets within the inner IPv4 and UDP headers
    localparam logic [7:0] OFF_INNER_PROTO  = 8'd9;
    localparam logic [7:0] OFF_INNER_DST    = 8'd19;
    localparam logic [7:0] OFF_UDP_DPORT    = 8'd3;
    localparam logic [7:0] OFF_UDP_END      = 8'd7;

    // One frame byte request
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic [7:0] rx_queue;
    } gmuf_req_t;

    // One frame verdict
    typedef struct packed {
        logic       verdict;
        logic [7:0] queue;
    } gmuf_result_t;

endpackage

// ===== rtl/gre_multicast_udp_filter_unit.sv =====
// ----------------------------------------------------------------------------
// gre_multicast_udp_filter_unit: GRE-tunnelled multicast UDP frame filter
// Byte-stream frame parser that redirects matching tunnelled multicast UDP
// frames to their receive queue and passes everything else.
// ----------------------------------------------------------------------------
// The filter takes one Ethernet frame byte per request on the slave stream,
// with tlast on the final byte and the receive queue in tuser. It checks the
// chain Ethernet (type 0x0800), outer IPv4 (protocol 47, header length 20 to
// 60 bytes), GRE (protocol 0x0800, optional checksum, key and sequence words),
// inner IPv4 (protocol 17, header length 20 to 60, destination in 224.0.0.0/4
// and equal to target_group) and UDP (destination port equal to target_port).
// Exactly one result request leaves on the master stream for each last byte:
// tuser is the verdict (1 redirect, 0 pass) and tdata the queue, which reads
// zero on pass. A frame that ends before the end of its UDP header is passed.
// The filter accepts one byte in every clock cycle while no last byte is held
// for a stalled master side; a result passes from the input register through
// the combinational parse step to the result register. Only a last byte waits
// for a stalled master side; other bytes keep flowing past a held result.
// Register writes (index 0 target_group, index 1 target_port) take effect at
// the next edge and belong between frames.
// ----------------------------------------------------------------------------
module gre_multicast_udp_filter_unit
    import gmuf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [7:0] frame_byte
    input  logic                     s_tlast,
    input  logic [7:0]               s_tuser,   // [7:0] rx_queue

    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,   // [7:0] queue
    output logic [0:0]               m_tuser,   // [0] verdict

    input  logic                     cfg_wr_en,
    input  logic [CfgIndexWidth-1:0] cfg_wr_index,
    input  logic [31:0]              cfg_wr_data
);

    logic [31:0]  target_group;
    logic [15:0]  target_port;

    logic         in_valid_reg;
    gmuf_req_t    in_req_reg;
    logic         out_valid_reg;
    gmuf_result_t out_result_reg;
    gmuf_result_t parse_result;

    logic         out_free;
    logic         take;

    gmuf_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .target_group (target_group),
        .target_port  (target_port)
    );

    // A byte leaves the input register when it yields no result, or when the
    // result register is empty or being emptied in this cycle.
    assign out_free = !out_valid_reg || m_tready;
    assign take     = in_valid_reg && (!in_req_reg.last_byte || out_free);
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg.frame_byte <= s_tdata;
            in_req_reg.last_byte  <= s_tlast;
            in_req_reg.rx_queue   <= s_tuser;
        end
    end

    gmuf_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .req          (in_req_reg),
        .target_group (target_group),
        .target_port  (target_port),
        .result       (parse_result)
    );

    // The result register is loaded by a last byte and emptied by the
    // master side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && in_req_reg.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && in_req_reg.last_byte) begin
            out_result_reg <= parse_result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_result_reg.queue;
    assign m_tuser[0] = out_result_reg.verdict;

    a_pass_zero_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("pass result carries a non-zero queue");

    a_last_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready && in_valid_reg && in_req_reg.last_byte |-> !take)
        else $error("last byte taken while the result register is held");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        take && in_req_reg.last_byte |=> out_valid_reg)
        else $error("last byte gave no result");

endmodule

// ===== rtl/gmuf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gmuf_cfg_regs: configuration registers
// Holds the target multicast group and the target UDP port.
// ----------------------------------------------------------------------------
module gmuf_cfg_regs
    import gmuf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CfgIndexWidth-1:0] cfg_wr_index,
    input  logic [31:0]              cfg_wr_data,
    output logic [31:0]              target_group,
    output logic [15:0]              target_port
);

    logic [31:0] group_reg;
    logic [15:0] port_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg <= '0;
            port_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_TARGET_GROUP: group_reg <= cfg_wr_data;
                CFG_TARGET_PORT:  port_reg  <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    assign target_group = group_reg;
    assign target_port  = port_reg;

endmodule

// ===== rtl/gmuf_parser.sv =====
// ----------------------------------------------------------------------------
// gmuf_parser: per-frame header parser
// Holds the parse state of the current frame and works out, in one step per
// byte, the updated state and the verdict that a last byte produces.
// ----------------------------------------------------------------------------
module gmuf_parser
    import gmuf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         take,
    input  gmuf_req_t    req,
    input  logic [31:0]  target_group,
    input  logic [15:0]  target_port,
    output gmuf_result_t result
);

    logic [7:0]  pos_reg, pos_next;
    logic        match_reg, match_next;
    logic [5:0]  outer_len_reg, outer_len_next;
    logic [7:0]  inner_start_reg, inner_start_next;
    logic [7:0]  transport_start_reg, transport_start_next;
    logic [31:0] shift_reg, shift_next;
    logic        done_reg, done_next;

    logic [7:0]  gre_start;
    logic [4:0]  gre_len;
    logic [5:0]  inner_ihl;
    logic [7:0]  b;

    always_comb begin
        b                    = req.frame_byte;
        shift_next           = {shift_reg[23:0], b};
        match_next           = match_reg;
        outer_len_next       = outer_len_reg;
        inner_start_next     = inner_start_reg;
        transport_start_next = transport_start_reg;
        done_next            = done_reg;
        gre_start            = '0;
        gre_len              = 5'd4;
        inner_ihl            = {b[3:0], 2'b00};

        if (match_reg) begin
            // Ethernet type and outer IPv4 header
            if (pos_reg == POS_ETH_TYPE_END && shift_next[15:0] != ETH_TYPE_IPV4) begin
                match_next = 1'b0;
            end
            if (pos_reg == POS_OUTER_IP) begin
                outer_len_next = {b[3:0], 2'b00};
                if ({b[3:0], 2'b00} < IHL_MIN) begin
                    match_next = 1'b0;
                end
            end
            if (pos_reg == POS_OUTER_PROTO && b != PROTO_GRE) begin
                match_next = 1'b0;
            end

            // GRE header: the flags word sets the tunnel header length
            gre_start = POS_OUTER_IP + {2'b00, outer_len_next};
            if (match_next && pos_reg >= POS_OUTER_END) begin
                if (pos_reg == gre_start + 8'd1) begin
                    gre_len = 5'd4 + (shift_next[GRE_BIT_CSUM] ? 5'd4 : 5'd0)
                                   + (shift_next[GRE_BIT_KEY]  ? 5'd4 : 5'd0)
                                   + (shift_next[GRE_BIT_SEQ]  ? 5'd4 : 5'd0);
                    inner_start_next = gre_start + {3'b000, gre_len};
                end
                if (pos_reg == gre_start + 8'd3 && shift_next[15:0] != ETH_TYPE_IPV4) begin
                    match_next = 1'b0;
                end
            end

            // Inner IPv4 header
            if (match_next && inner_start_next != '0) begin
                if (pos_reg == inner_start_next) begin
                    if (inner_ihl < IHL_MIN) begin
                        match_next = 1'b0;
                    end
                    transport_start_next = inner_start_next + {2'b00, inner_ihl};
                end
                if (pos_reg == inner_start_next + OFF_INNER_PROTO && b != PROTO_UDP) begin
                    match_next = 1'b0;
                end
                if (pos_reg == inner_start_next + OFF_INNER_DST) begin
                    if (shift_next[31:28] != MCAST_PREFIX || shift_next != target_group) begin
                        match_next = 1'b0;
                    end
                end
            end

            // UDP header
            if (match_next && transport_start_next != '0) begin
                if (pos_reg == transport_start_next + OFF_UDP_DPORT
                        && shift_next[15:0] != target_port) begin
                    match_next = 1'b0;
                end
                if (pos_reg == transport_start_next + OFF_UDP_END) begin
                    done_next = 1'b1;
                end
            end
        end

        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 8'd1;

        result.verdict = match_next && done_next;
        result.queue   = (match_next && done_next) ? req.rx_queue : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg             <= '0;
            match_reg           <= 1'b1;
            outer_len_reg       <= '0;
            inner_start_reg     <= '0;
            transport_start_reg <= '0;
            shift_reg           <= '0;
            done_reg            <= 1'b0;
        end else if (take) begin
            if (req.last_byte) begin
                // Every frame starts from a clean parse state.
                pos_reg             <= '0;
                match_reg           <= 1'b1;
                outer_len_reg       <= '0;
                inner_start_reg     <= '0;
                transport_start_reg <= '0;
                shift_reg           <= '0;
                done_reg            <= 1'b0;
            end else begin
                pos_reg             <= pos_next;
                match_reg           <= match_next;
                outer_len_reg       <= outer_len_next;
                inner_start_reg     <= inner_start_next;
                transport_start_reg <= transport_start_next;
                shift_reg           <= shift_next;
                done_reg            <= done_next;
            end
        end
    end

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        take && req.last_byte |=> pos_reg == '0 && match_reg && !done_reg)
        else $error("parse state not cleared after last byte");

    a_fail_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !req.last_byte && !match_reg |=> !match_reg)
        else $error("failed frame recovered its match");

    a_done_needs_udp: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> transport_start_reg != '0 && inner_start_reg != '0)
        else $error("headers complete without located UDP header");

endmodule
